// ===== design/ndma_pkg.sv =====
// Shared types, codes and helper functions for the DMA channel controller.
// No dependencies; every other design file but ndma_fifo refers to this package by scope.
`default_nettype none
package ndma_pkg;

   localparam int          MAX_CHANNELS = 8;
   localparam logic [7:0]  BLOCK_STRIDE = 8'h1C;
   localparam logic [31:0] CTRL_MASK    = 32'hFF0FFC00;
   localparam logic [31:0] ADDR_MASK    = 32'hFFFFFFFC;

   typedef enum logic [2:0] {
      FN_WRITE = 3'd0,
      FN_READ  = 3'd1,
      FN_SET   = 3'd2,
      FN_CLEAR = 3'd3,
      FN_CHECK = 3'd4,
      FN_TICK  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_DESC = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_INC  = 2'd0,
      MODE_DEC  = 2'd1,
      MODE_FIX  = 2'd2,
      MODE_FILL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_GLOBAL,
      REG_SRC,
      REG_DST,
      REG_CNT,
      REG_WORDS,
      REG_FILL,
      REG_CTRL,
      REG_NONE
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  reg_address;
      logic [31:0] write_data;
      logic [3:0]  request_line;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] read_data;
      logic [2:0]  channel;
      logic [31:0] src_start;
      logic [31:0] dest_start;
      logic [1:0]  src_mode;
      logic [1:0]  dest_mode;
      logic [23:0] word_count;
      logic        raise_irq;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  func;
      reg_type     reg_code;
      logic [2:0]  chan;
      logic [31:0] data;
      logic [3:0]  request_line;
   } cmd_type;

   typedef struct packed {
      logic [31:0] ctrl;
      logic [27:0] count;
      logic [31:0] ws;
      logic [31:0] wd;
      rsp_type     rsp;
   } run_type;

   function automatic logic [31:0] advance(logic [31:0] a, logic [1:0] mode,
                                           logic [23:0] words);
      logic [31:0] span;
      span = {6'd0, words, 2'b00};
      case (mode)
         MODE_INC: advance = a + span;
         MODE_DEC: advance = a - span;
         default:  advance = a;
      endcase
   endfunction

   function automatic run_type ch_run(logic [31:0] ctrl, logic [23:0] words,
                                      logic [27:0] count, logic [31:0] ws,
                                      logic [31:0] wd, logic [2:0] ch);
      run_type     r;
      logic [1:0]  sm;
      logic [1:0]  dm;
      logic        done;
      sm = ctrl[14:13];
      dm = ctrl[11:10];
      done = 1'b0;
      r.ctrl = ctrl;
      r.count = count;
      r.ws = ws;
      r.wd = wd;
      r.rsp = '0;
      r.rsp.channel = ch;
      if (sm == MODE_FILL || dm == MODE_FILL) begin
         r.ctrl[31] = 1'b0;
         r.rsp.kind = KIND_ERR;
      end else begin
         if (!ctrl[15]) r.ws = advance(ws, sm, words);
         if (!ctrl[12]) r.wd = advance(wd, dm, words);
         if (ctrl[28]) begin
            done = 1'b1;
         end else if (!ctrl[29]) begin
            r.count = count - {4'd0, words};
            done = (r.count == 28'd0);
         end
         if (done) r.ctrl[31] = 1'b0;
         r.rsp.kind = KIND_DESC;
         r.rsp.src_start = ws;
         r.rsp.dest_start = wd;
         r.rsp.src_mode = sm;
         r.rsp.dest_mode = dm;
         r.rsp.word_count = words;
         r.rsp.raise_irq = done & ctrl[30];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/ndma_fifo.sv =====
// Small register-based FIFO of WIDTH-bit beats, DEPTH a power of two.
// Standalone; used for the command queue and the result queue.
`default_nettype none
module ndma_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ff, wr_in;
   logic [AW:0]      rd_ff, rd_in;

   assign empty    = (wr_ff == rd_ff);
   assign full     = (wr_ff == {~rd_ff[AW], rd_ff[AW-1:0]});
   assign pop_data = mem_ff[rd_ff[AW-1:0]];
   assign wr_in    = (push && !full) ? wr_ff + 1'b1 : wr_ff;
   assign rd_in    = (pop && !empty) ? rd_ff + 1'b1 : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff[AW-1:0]] <= push_data;
   end
endmodule
`default_nettype wire

// ===== design/ndma_front.sv =====
// Front end: accepts request beats, decodes the register offset into
// channel and register code, and queues commands. Uses ndma_pkg, ndma_fifo.
`default_nettype none
module ndma_front #(
   parameter int NUM_CHANNELS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire ndma_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             cmd_pop,
   output ndma_pkg::cmd_type     cmd_data,
   output logic                  cmd_empty
);
   ndma_pkg::cmd_type cmd;
   logic [7:0]        off;
   logic [7:0]        rel;
   logic [3:0]        idx;
   logic [7:0]        base;

   always_comb begin
      off  = req_data.reg_address - 8'd4;
      idx  = 4'd0;
      base = 8'd0;
      for (int k = 1; k <= ndma_pkg::MAX_CHANNELS; k++) begin
         if (off >= 8'(k * 28)) begin
            idx  = 4'(k);
            base = 8'(k * 28);
         end
      end
      rel = off - base;
      cmd.func         = req_data.func;
      cmd.data         = req_data.write_data;
      cmd.request_line = req_data.request_line;
      cmd.chan         = idx[2:0];
      if (req_data.reg_address == 8'd0) begin
         cmd.reg_code = ndma_pkg::REG_GLOBAL;
      end else if (req_data.reg_address < 8'd4 || idx >= 4'(NUM_CHANNELS)) begin
         cmd.reg_code = ndma_pkg::REG_NONE;
      end else begin
         case (rel)
            8'h00:   cmd.reg_code = ndma_pkg::REG_SRC;
            8'h04:   cmd.reg_code = ndma_pkg::REG_DST;
            8'h08:   cmd.reg_code = ndma_pkg::REG_CNT;
            8'h0C:   cmd.reg_code = ndma_pkg::REG_WORDS;
            8'h14:   cmd.reg_code = ndma_pkg::REG_FILL;
            8'h18:   cmd.reg_code = ndma_pkg::REG_CTRL;
            default: cmd.reg_code = ndma_pkg::REG_NONE;
         endcase
      end
   end

   ndma_fifo #(
      .WIDTH($bits(ndma_pkg::cmd_type)),
      .DEPTH(2)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .pop_data (cmd_data),
      .empty    (cmd_empty)
   );
endmodule
`default_nettype wire

// ===== design/ndma_back.sv =====
// Back end: channel register file, request flags and the service scan.
// Executes queued commands and emits result beats. Uses ndma_pkg.
`default_nettype none
module ndma_back #(
   parameter int NUM_CHANNELS = 8,
   parameter int AES2_MODE    = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   input  wire ndma_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   input  wire logic              out_full,
   output logic                   out_push,
   output ndma_pkg::rsp_type      out_data
);
   logic [31:0] src_ff   [NUM_CHANNELS], src_in   [NUM_CHANNELS];
   logic [31:0] dst_ff   [NUM_CHANNELS], dst_in   [NUM_CHANNELS];
   logic [27:0] cnt_ff   [NUM_CHANNELS], cnt_in   [NUM_CHANNELS];
   logic [23:0] words_ff [NUM_CHANNELS], words_in [NUM_CHANNELS];
   logic [31:0] fill_ff  [NUM_CHANNELS], fill_in  [NUM_CHANNELS];
   logic [31:0] ctrl_ff  [NUM_CHANNELS], ctrl_in  [NUM_CHANNELS];
   logic [31:0] ws_ff    [NUM_CHANNELS], ws_in    [NUM_CHANNELS];
   logic [31:0] wd_ff    [NUM_CHANNELS], wd_in    [NUM_CHANNELS];
   logic [15:0] pend_ff, pend_in;
   logic [31:0] gc_ff, gc_in;

   ndma_pkg::state_type state_ff, state_in;
   logic [3:0]          scan_ff, scan_in;
   logic                chain_ff, chain_in;
   logic                held_v_ff, held_v_in;
   ndma_pkg::rsp_type   held_ff, held_in;

   logic [2:0]        sel;
   logic [31:0]       newc;
   logic              hit;
   logic              run;
   ndma_pkg::run_type r;

   always_comb begin
      src_in   = src_ff;
      dst_in   = dst_ff;
      cnt_in   = cnt_ff;
      words_in = words_ff;
      fill_in  = fill_ff;
      ctrl_in  = ctrl_ff;
      ws_in    = ws_ff;
      wd_in    = wd_ff;
      pend_in  = pend_ff;
      gc_in    = gc_ff;
      state_in  = state_ff;
      scan_in   = scan_ff;
      chain_in  = chain_ff;
      held_v_in = held_v_ff;
      held_in   = held_ff;
      cmd_pop  = 1'b0;
      out_push = 1'b0;
      out_data = '0;
      newc     = '0;
      hit      = 1'b0;
      run      = 1'b0;
      sel = (state_ff == ndma_pkg::ST_SCAN) ? scan_ff[2:0] : cmd_data.chan;
      r = ndma_pkg::ch_run(ctrl_ff[sel], words_ff[sel], cnt_ff[sel],
                           ws_ff[sel], wd_ff[sel], sel);
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (ctrl_ff[k][31] && ctrl_ff[k][27:24] == cmd_data.request_line) hit = 1'b1;
      end
      case (state_ff)
         ndma_pkg::ST_IDLE: begin
            if (!cmd_empty && !out_full) begin
               cmd_pop = 1'b1;
               case (cmd_data.func)
                  ndma_pkg::FN_WRITE: begin
                     case (cmd_data.reg_code)
                        ndma_pkg::REG_GLOBAL: gc_in = cmd_data.data;
                        ndma_pkg::REG_SRC:   src_in[sel] = cmd_data.data & ndma_pkg::ADDR_MASK;
                        ndma_pkg::REG_DST:   dst_in[sel] = cmd_data.data & ndma_pkg::ADDR_MASK;
                        ndma_pkg::REG_CNT:   cnt_in[sel] = cmd_data.data[27:0];
                        ndma_pkg::REG_WORDS: words_in[sel] = cmd_data.data[23:0];
                        ndma_pkg::REG_FILL:  fill_in[sel] = cmd_data.data;
                        ndma_pkg::REG_CTRL: begin
                           newc = cmd_data.data & ndma_pkg::CTRL_MASK;
                           ctrl_in[sel] = newc;
                           if (!ctrl_ff[sel][31] && newc[31]) begin
                              ws_in[sel] = src_ff[sel];
                              wd_in[sel] = dst_ff[sel];
                              if (newc[28]) begin
                                 r = ndma_pkg::ch_run(newc, words_ff[sel], cnt_ff[sel],
                                                      src_ff[sel], dst_ff[sel], sel);
                                 ctrl_in[sel] = r.ctrl;
                                 cnt_in[sel]  = r.count;
                                 ws_in[sel]   = r.ws;
                                 wd_in[sel]   = r.wd;
                                 out_push = 1'b1;
                                 out_data = r.rsp;
                                 out_data.last = 1'b1;
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
                  ndma_pkg::FN_READ: begin
                     out_push = 1'b1;
                     out_data.kind = ndma_pkg::KIND_READ;
                     out_data.last = 1'b1;
                     case (cmd_data.reg_code)
                        ndma_pkg::REG_GLOBAL: out_data.read_data = gc_ff;
                        ndma_pkg::REG_SRC:    out_data.read_data = src_ff[sel];
                        ndma_pkg::REG_DST:    out_data.read_data = dst_ff[sel];
                        ndma_pkg::REG_CNT:    out_data.read_data = {4'd0, cnt_ff[sel]};
                        ndma_pkg::REG_WORDS:  out_data.read_data = {8'd0, words_ff[sel]};
                        ndma_pkg::REG_FILL:   out_data.read_data = fill_ff[sel];
                        ndma_pkg::REG_CTRL:   out_data.read_data = ctrl_ff[sel];
                        default:              out_data.read_data = '0;
                     endcase
                  end
                  ndma_pkg::FN_SET:   pend_in[cmd_data.request_line] = 1'b1;
                  ndma_pkg::FN_CLEAR: pend_in[cmd_data.request_line] = 1'b0;
                  ndma_pkg::FN_CHECK: pend_in[cmd_data.request_line] = hit;
                  ndma_pkg::FN_TICK: begin
                     state_in  = ndma_pkg::ST_SCAN;
                     scan_in   = '0;
                     chain_in  = 1'b0;
                     held_v_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ndma_pkg::ST_SCAN: begin
            if (scan_ff >= 4'(NUM_CHANNELS)) begin
               state_in = ndma_pkg::ST_FLUSH;
            end else begin
               run = (chain_ff && ctrl_ff[sel][27:24] == 4'(AES2_MODE)) ||
                     (ctrl_ff[sel][31] && pend_ff[ctrl_ff[sel][27:24]]);
               if (!run) begin
                  chain_in = 1'b0;
                  scan_in  = scan_ff + 1'b1;
               end else if (!(held_v_ff && out_full)) begin
                  out_push     = held_v_ff;
                  out_data     = held_ff;
                  held_in      = r.rsp;
                  held_v_in    = 1'b1;
                  ctrl_in[sel] = r.ctrl;
                  cnt_in[sel]  = r.count;
                  ws_in[sel]   = r.ws;
                  wd_in[sel]   = r.wd;
                  chain_in     = 1'b1;
                  scan_in      = scan_ff + 1'b1;
               end
            end
         end
         ndma_pkg::ST_FLUSH: begin
            if (!held_v_ff) begin
               state_in = ndma_pkg::ST_IDLE;
            end else if (!out_full) begin
               out_push      = 1'b1;
               out_data      = held_ff;
               out_data.last = 1'b1;
               held_v_in     = 1'b0;
               state_in      = ndma_pkg::ST_IDLE;
            end
         end
         default: state_in = ndma_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ndma_pkg::ST_IDLE;
         scan_ff   <= '0;
         chain_ff  <= 1'b0;
         held_v_ff <= 1'b0;
         pend_ff   <= '0;
         gc_ff     <= '0;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            src_ff[k]   <= '0;
            dst_ff[k]   <= '0;
            cnt_ff[k]   <= '0;
            words_ff[k] <= '0;
            fill_ff[k]  <= '0;
            ctrl_ff[k]  <= '0;
            ws_ff[k]    <= '0;
            wd_ff[k]    <= '0;
         end
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         chain_ff  <= chain_in;
         held_v_ff <= held_v_in;
         pend_ff   <= pend_in;
         gc_ff     <= gc_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         cnt_ff    <= cnt_in;
         words_ff  <= words_in;
         fill_ff   <= fill_in;
         ctrl_ff   <= ctrl_in;
         ws_ff     <= ws_in;
         wd_ff     <= wd_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end
endmodule
`default_nettype wire

// ===== design/ndma_channel_controller.sv =====
// Top level of the eight-channel DMA register block.
// Instantiates ndma_front, ndma_back and the result ndma_fifo; uses ndma_pkg.
//
// Request beats enter a two-deep command queue; results leave through a
// four-deep queue. A bus access, request set/clear/check or a start with
// immediate run is executed directly from ST_IDLE in the back end. A
// service tick is accepted in ST_IDLE, then ST_SCAN visits the channels in
// turn in a sequential channel scan and ends it, and ST_FLUSH pushes the
// last held beat; the back end stalls only while the result queue is full.
`default_nettype none
module ndma_channel_controller #(
   parameter int NUM_CHANNELS = 8,
   parameter int AES2_MODE    = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire ndma_pkg::req_type req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output ndma_pkg::rsp_type      rsp_data
);
   ndma_pkg::cmd_type cmd_data;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              out_full;
   logic              out_push;
   ndma_pkg::rsp_type out_data;

   ndma_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_pop  (cmd_pop),
      .cmd_data (cmd_data),
      .cmd_empty(cmd_empty)
   );

   ndma_back #(.NUM_CHANNELS(NUM_CHANNELS), .AES2_MODE(AES2_MODE)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data)
   );

   ndma_fifo #(
      .WIDTH($bits(ndma_pkg::rsp_type)),
      .DEPTH(4)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .push_data(out_data),
      .full     (out_full),
      .pop      (rsp_pop),
      .pop_data (rsp_data),
      .empty    (rsp_empty)
   );
endmodule
`default_nettype wire

// ===== design/ndma_checker.sv =====
// Port-level checks for the DMA channel controller, bound to the top level.
// Uses ndma_pkg.
`default_nettype none
module ndma_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire ndma_pkg::rsp_type rsp_data
);
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled result beat changed");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.kind != 2'd3)
      else $error("bad result kind");
   a_read_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.kind == ndma_pkg::KIND_READ |-> rsp_data.last)
      else $error("read result not marked last");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.kind == ndma_pkg::KIND_ERR |->
         rsp_data.src_start == 32'd0 && rsp_data.word_count == 24'd0)
      else $error("error result carries descriptor fields");
endmodule

bind ndma_channel_controller ndma_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_empty(rsp_empty),
   .rsp_pop  (rsp_pop),
   .rsp_data (rsp_data)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the eight-channel DMA register block.
// Depends on ndma_pkg and ndma_channel_controller; the predictor is built in.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH   = 8;
   localparam int AES2  = 11;
   localparam int LIMIT = 400000;

   logic              clock, reset;
   logic              req_push;
   ndma_pkg::req_type req_data;
   logic              req_full, rsp_empty, rsp_pop;
   ndma_pkg::rsp_type rsp_data;

   ndma_channel_controller #(.NUM_CHANNELS(NCH), .AES2_MODE(AES2)) u_dut (
      .clock, .reset, .req_push, .req_data, .req_full, .rsp_empty, .rsp_pop, .rsp_data
   );

   // predictor state
   logic [31:0] m_src [NCH];
   logic [31:0] m_dst [NCH];
   logic [27:0] m_cnt [NCH];
   logic [23:0] m_words [NCH];
   logic [31:0] m_fill [NCH];
   logic [31:0] m_ctrl [NCH];
   logic [31:0] m_ws [NCH];
   logic [31:0] m_wd [NCH];
   logic [15:0] m_pend;
   logic [31:0] m_glob;

   ndma_pkg::rsp_type expected_rsps[$];
   int      errors, mismatches, cycles;
   bit      stim_done;

   function automatic logic [31:0] step_addr(logic [31:0] a, logic [1:0] mode,
                                             logic [23:0] w);
      logic [31:0] span;
      span = {6'd0, w, 2'b00};
      if (mode == ndma_pkg::MODE_INC) return a + span;
      if (mode == ndma_pkg::MODE_DEC) return a - span;
      return a;
   endfunction

   task automatic channel_beat(int ch, inout ndma_pkg::rsp_type list[$]);
      ndma_pkg::rsp_type r;
      logic [1:0]  sm, dm;
      logic        done;
      sm = m_ctrl[ch][14:13];
      dm = m_ctrl[ch][11:10];
      done = 0;
      r = '0;
      r.channel = ch[2:0];
      if (sm == ndma_pkg::MODE_FILL || dm == ndma_pkg::MODE_FILL) begin
         m_ctrl[ch][31] = 0;
         r.kind = ndma_pkg::KIND_ERR;
      end else begin
         r.kind = ndma_pkg::KIND_DESC;
         r.src_start = m_ws[ch];
         r.dest_start = m_wd[ch];
         r.src_mode = sm;
         r.dest_mode = dm;
         r.word_count = m_words[ch];
         if (!m_ctrl[ch][15]) m_ws[ch] = step_addr(m_ws[ch], sm, m_words[ch]);
         if (!m_ctrl[ch][12]) m_wd[ch] = step_addr(m_wd[ch], dm, m_words[ch]);
         if (m_ctrl[ch][28]) done = 1;
         else if (!m_ctrl[ch][29]) begin
            m_cnt[ch] = m_cnt[ch] - {4'd0, m_words[ch]};
            done = (m_cnt[ch] == 0);
         end
         if (done) m_ctrl[ch][31] = 0;
         r.raise_irq = done & m_ctrl[ch][30];
      end
      list.push_back(r);
   endtask

   function automatic void decode(logic [7:0] a, output int ch, output int off);
      ch = (int'(a) - 4) / 28;
      off = (int'(a) - 4) % 28;
   endfunction

   task automatic predict(ndma_pkg::req_type q, inout ndma_pkg::rsp_type list[$]);
      int     ch, off;
      logic   was, hit;
      ndma_pkg::rsp_type r;
      case (q.func)
         ndma_pkg::FN_WRITE: begin
            if (q.reg_address == 0) m_glob = q.write_data;
            else if (q.reg_address >= 4) begin
               decode(q.reg_address, ch, off);
               if (ch < NCH) case (off)
                  0:  m_src[ch] = q.write_data & ndma_pkg::ADDR_MASK;
                  4:  m_dst[ch] = q.write_data & ndma_pkg::ADDR_MASK;
                  8:  m_cnt[ch] = q.write_data[27:0];
                  12: m_words[ch] = q.write_data[23:0];
                  20: m_fill[ch] = q.write_data;
                  24: begin
                     was = m_ctrl[ch][31];
                     m_ctrl[ch] = q.write_data & ndma_pkg::CTRL_MASK;
                     if (!was && m_ctrl[ch][31]) begin
                        m_ws[ch] = m_src[ch];
                        m_wd[ch] = m_dst[ch];
                        if (m_ctrl[ch][28]) channel_beat(ch, list);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ndma_pkg::FN_READ: begin
            r = '0;
            r.kind = ndma_pkg::KIND_READ;
            if (q.reg_address == 0) r.read_data = m_glob;
            else if (q.reg_address >= 4) begin
               decode(q.reg_address, ch, off);
               if (ch < NCH) case (off)
                  0:  r.read_data = m_src[ch];
                  4:  r.read_data = m_dst[ch];
                  8:  r.read_data = {4'd0, m_cnt[ch]};
                  12: r.read_data = {8'd0, m_words[ch]};
                  20: r.read_data = m_fill[ch];
                  24: r.read_data = m_ctrl[ch];
                  default: ;
               endcase
            end
            list.push_back(r);
         end
         ndma_pkg::FN_SET:   m_pend[q.request_line] = 1;
         ndma_pkg::FN_CLEAR: m_pend[q.request_line] = 0;
         ndma_pkg::FN_CHECK: begin
            hit = 0;
            for (int i = 0; i < NCH; i++)
               if (m_ctrl[i][31] && m_ctrl[i][27:24] == q.request_line) hit = 1;
            m_pend[q.request_line] = hit;
         end
         ndma_pkg::FN_TICK: begin
            for (int i = 0; i < NCH; i++) begin
               if (m_ctrl[i][31] && m_pend[m_ctrl[i][27:24]]) begin
                  channel_beat(i, list);
                  while (i + 1 < NCH && m_ctrl[i + 1][27:24] == AES2) begin
                     i++;
                     channel_beat(i, list);
                  end
               end
            end
         end
         default: ;
      endcase
      if (list.size() > 0) list[list.size() - 1].last = 1;
   endtask

   // directed table
   typedef struct {
      ndma_pkg::req_type q;
      bit      has_val;
      logic [31:0] rd;
   } row_type;
   row_type rows[$];

   function automatic ndma_pkg::req_type mk(ndma_pkg::func_type f, int a, logic [31:0] d,
                                            int rl);
      ndma_pkg::req_type q;
      q.func = f;
      q.reg_address = a[7:0];
      q.write_data = d;
      q.request_line = rl[3:0];
      return q;
   endfunction

   function automatic int caddr(int ch, int off);
      return 4 + ch * 28 + off;
   endfunction

   function automatic void add(ndma_pkg::req_type q, bit hv = 0, logic [31:0] rd = 0);
      row_type r;
      r.q = q;
      r.has_val = hv;
      r.rd = rd;
      rows.push_back(r);
   endfunction

   function automatic logic [31:0] ctrl_word(int dm, int drl, int sm, int srl, int st,
                                             int imm, int rep, int irq, int busy);
      logic [31:0] c;
      c = '0;
      c[11:10] = dm[1:0];
      c[12] = drl[0];
      c[14:13] = sm[1:0];
      c[15] = srl[0];
      c[19:16] = 4'($urandom_range(0, 15));
      c[27:24] = st[3:0];
      c[28] = imm[0];
      c[29] = rep[0];
      c[30] = irq[0];
      c[31] = busy[0];
      return c;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // sender
   task automatic send(ndma_pkg::req_type q);
      req_push <= 1;
      req_data <= q;
      do @(posedge clock); while (req_full);
   endtask

   task automatic idle_gap();
      req_push <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   int burst;
   task automatic send_paced(ndma_pkg::req_type q);
      if (burst == 0) begin
         burst = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) idle_gap();
      end
      burst--;
      send(q);
   endtask

   task automatic drain();
      req_push <= 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic ndma_pkg::req_type rand_item();
      ndma_pkg::req_type q;
      int      p, ch;
      q.write_data = $urandom;
      q.request_line = 4'($urandom_range(0, 15));
      p = $urandom_range(0, 99);
      ch = $urandom_range(0, NCH - 1);
      if (p < 20) begin
         q.func = ndma_pkg::FN_TICK;
         q.reg_address = 8'($urandom);
      end else if (p < 55) begin
         q.func = ndma_pkg::FN_WRITE;
         case ($urandom_range(0, 5))
            0: q.reg_address = 8'($urandom);
            1: begin
               q.reg_address = 8'(caddr(ch, 24));
               q.write_data = ctrl_word($urandom_range(0, 2), $urandom_range(0, 1),
                  $urandom_range(0, 2), $urandom_range(0, 1),
                  ($urandom_range(0, 3) == 0) ? AES2 : $urandom_range(0, 15),
                  $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                  $urandom_range(0, 1), 1);
               if ($urandom_range(0, 15) == 0) q.write_data = $urandom;
            end
            2: begin
               q.reg_address = 8'(caddr(ch, 8));
               q.write_data = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40);
            end
            3: begin
               q.reg_address = 8'(caddr(ch, 12));
               q.write_data = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8);
            end
            default: q.reg_address = 8'(caddr(ch, 4 * $urandom_range(0, 6)));
         endcase
      end else if (p < 75) begin
         q.func = ndma_pkg::FN_READ;
         q.reg_address = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                     : 8'(caddr(ch, 4 * $urandom_range(0, 6)));
      end else begin
         q.func = ndma_pkg::func_type'(3'($urandom_range(2, 7)));
         q.reg_address = 8'($urandom);
      end
      return q;
   endfunction

   // stimulus
   initial begin
      row_type rw;
      ndma_pkg::rsp_type tmp[$];
      ndma_pkg::req_type q;
      reset = 1;
      req_push = 0;
      req_data = '0;
      errors = 0;
      mismatches = 0;
      stim_done = 0;
      burst = 0;
      m_src = '{default: 0}; m_dst = '{default: 0}; m_cnt = '{default: 0};
      m_words = '{default: 0}; m_fill = '{default: 0}; m_ctrl = '{default: 0};
      m_ws = '{default: 0}; m_wd = '{default: 0};
      m_pend = '0; m_glob = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add(mk(ndma_pkg::FN_READ, 0, 0, 0), 1, 0);
      add(mk(ndma_pkg::FN_READ, caddr(7, 24), 0, 0), 1, 0);
      add(mk(ndma_pkg::FN_WRITE, 0, 32'hFFFFFFFF, 0));
      add(mk(ndma_pkg::FN_READ, 0, 0, 0), 1, 32'hFFFFFFFF);
      add(mk(ndma_pkg::FN_WRITE, 2, 32'h12345678, 0));
      add(mk(ndma_pkg::FN_READ, 2, 0, 0), 1, 0);
      add(mk(ndma_pkg::FN_WRITE, caddr(0, 0), 32'hFFFFFFFF, 0));
      add(mk(ndma_pkg::FN_READ, caddr(0, 0), 0, 0), 1, 32'hFFFFFFFC);
      add(mk(ndma_pkg::FN_WRITE, caddr(0, 8), 32'hFFFFFFFF, 0));
      add(mk(ndma_pkg::FN_READ, caddr(0, 8), 0, 0), 1, 32'h0FFFFFFF);
      add(mk(ndma_pkg::FN_WRITE, caddr(0, 16), 32'hFFFFFFFF, 0));
      add(mk(ndma_pkg::FN_READ, caddr(0, 16), 0, 0), 1, 0);
      add(mk(ndma_pkg::FN_WRITE, caddr(7, 12), 32'hFFFFFFFF, 0));
      add(mk(ndma_pkg::FN_READ, caddr(7, 12), 0, 0), 1, 32'h00FFFFFF);
      add(mk(ndma_pkg::FN_WRITE, caddr(1, 20), 32'hA5A5A5A5, 0));
      add(mk(ndma_pkg::FN_READ, 8'hFF, 0, 0), 1, 0);
      add(mk(ndma_pkg::FN_WRITE, caddr(1, 12), 3, 0));
      add(mk(ndma_pkg::FN_WRITE, caddr(1, 8), 6, 0));
      add(mk(ndma_pkg::FN_WRITE, caddr(1, 24), ctrl_word(0, 0, 1, 0, 4, 0, 0, 1, 1), 0));
      add(mk(ndma_pkg::FN_WRITE, caddr(2, 24), ctrl_word(2, 1, 2, 1, AES2, 0, 1, 0, 0), 0));
      add(mk(ndma_pkg::FN_WRITE, caddr(3, 24), ctrl_word(3, 0, 0, 0, AES2, 0, 0, 0, 1), 0));
      add(mk(ndma_pkg::FN_CHECK, 0, 0, 4));
      add(mk(ndma_pkg::FN_TICK, 0, 0, 0));
      add(mk(ndma_pkg::FN_TICK, 0, 0, 0));
      add(mk(ndma_pkg::FN_WRITE, caddr(0, 24), ctrl_word(0, 0, 3, 0, 0, 1, 0, 1, 1), 0));
      add(mk(ndma_pkg::FN_CLEAR, 0, 0, 4));
      add(mk(ndma_pkg::func_type'(3'd7), 0, 0, 0));

      foreach (rows[i]) begin
         rw = rows[i];
         tmp = {};
         predict(rw.q, tmp);
         if (rw.has_val && (tmp.size() != 1 || tmp[0].read_data != rw.rd)) begin
            errors++;
            $display("directed row %0d: predictor %h, table %h", i, tmp[0].read_data, rw.rd);
         end
         foreach (tmp[k]) expected_rsps.push_back(tmp[k]);
         send_paced(rw.q);
      end

      for (int n = 0; n < 470; n++) begin
         q = rand_item();
         tmp = {};
         predict(q, tmp);
         foreach (tmp[k]) expected_rsps.push_back(tmp[k]);
         send_paced(q);
      end
      drain();
      stim_done = 1;
   end

   // receiver stall pattern
   logic [15:0] stall_pat;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 0;
         stall_pat <= 16'hB3C1;
      end else begin
         stall_pat <= {stall_pat[14:0], stall_pat[15] ^ stall_pat[13] ^ stall_pat[12] ^ stall_pat[10]};
         rsp_pop <= (cycles % 600 < 200) ? 1'b1 : stall_pat[0] | stall_pat[3];
      end
   end

   // checker
   always @(posedge clock) begin
      ndma_pkg::rsp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected beat %p", rsp_data);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               errors++;
               if (mismatches++ < 10) $display("mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (stim_done) begin
            if (errors == 0 && expected_rsps.size() == 0)
               $display("Test completed successfully");
            else
               $display("Test completed with failures");
            $finish;
         end
         if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire
